// ===== rtl/nearest_key_classifier_macros.svh =====
// assertion macros for the nearest key classifier
// used by nearest_key_classifier.sv, expects clk and rst_n in scope
`ifndef NEAREST_KEY_CLASSIFIER_MACROS_SVH
`define NEAREST_KEY_CLASSIFIER_MACROS_SVH

// checked only outside reset
`define NKC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define NKC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nkc_pkg.sv =====
// types, key layout tables and root step function for the nearest key classifier
// no dependencies
`timescale 1ns / 1ps

package nkc_pkg;

    localparam int LAYOUT_SIZE = 33;
    localparam int COORD_W     = 10;
    localparam int SUM_W       = 21;
    localparam int RAD_W       = 22;
    localparam int REM_W       = 14;
    localparam int ROOT_W      = 11;
    localparam int DIST_W      = 12;
    localparam int IDX_W       = 6;
    localparam int CODE_W      = 7;

    localparam logic [DIST_W-1:0] DIST_PAD = {DIST_W{1'b1}};

    localparam logic [CODE_W-1:0] KC_BS  = 7'h08;
    localparam logic [CODE_W-1:0] KC_RET = 7'h0D;
    localparam logic [CODE_W-1:0] KC_SH  = 7'h0F;
    localparam logic [CODE_W-1:0] KC_SP  = 7'h20;

    localparam logic [COORD_W-1:0] CENTRE_X [LAYOUT_SIZE] = '{
        10'd20,  10'd63,  10'd105, 10'd150, 10'd193, 10'd236, 10'd279, 10'd324,
        10'd367, 10'd410, 10'd455,
        10'd37,  10'd80,  10'd123, 10'd167, 10'd210, 10'd252, 10'd296, 10'd339,
        10'd382, 10'd440,
        10'd19,  10'd60,  10'd103, 10'd145, 10'd188, 10'd232, 10'd274, 10'd317,
        10'd358, 10'd401, 10'd450,
        10'd252
    };

    localparam logic [COORD_W-1:0] CENTRE_Y [LAYOUT_SIZE] = '{
        10'd175, 10'd175, 10'd175, 10'd175, 10'd175, 10'd175, 10'd175, 10'd175,
        10'd175, 10'd175, 10'd175,
        10'd214, 10'd214, 10'd214, 10'd214, 10'd214, 10'd214, 10'd214, 10'd214,
        10'd214, 10'd214,
        10'd253, 10'd253, 10'd253, 10'd253, 10'd253, 10'd253, 10'd253, 10'd253,
        10'd253, 10'd253, 10'd253,
        10'd294
    };

    localparam logic [CODE_W-1:0] CODES_UP [LAYOUT_SIZE] = '{
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, KC_BS,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, KC_RET,
        KC_SH, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h21, 7'h3F, KC_SH,
        KC_SP
    };

    localparam logic [CODE_W-1:0] CODES_LOW [LAYOUT_SIZE] = '{
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, KC_BS,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, KC_RET,
        KC_SH, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, KC_SH,
        KC_SP
    };

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    // one restoring root digit
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
        sqrt_state_t      r;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        r     = s;
        rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        return r;
    endfunction

    function automatic sqrt_state_t sqrt_steps(input sqrt_state_t s, input int unsigned n);
        sqrt_state_t r;
        r = s;
        for (int i = 0; i < 4; i++)
        begin
            if (i < n)
            begin
                r = sqrt_step(r);
            end
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] key_code_of(input logic [IDX_W-1:0] idx,
                                                      input logic up);
        logic [CODE_W-1:0] c;
        c = KC_SP;
        if (idx < IDX_W'(LAYOUT_SIZE))
        begin
            c = up ? CODES_UP[idx] : CODES_LOW[idx];
        end
        return c;
    endfunction

endpackage

// ===== rtl/nearest_key_classifier.sv =====
// nearest key classifier: one touch request per cycle while key_ready does not
// hold the output; per-key distance lanes, a three-stage root pipeline and a
// registered min tree, one tree level per stage
// reset clears the stage valid bits only; no state is kept between requests
// depends on nkc_pkg and nearest_key_classifier_macros.svh
`timescale 1ns / 1ps
`include "nearest_key_classifier_macros.svh"

module nearest_key_classifier #(
    parameter int NUM_KEYS = 33
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       touch_valid,
    output logic                       touch_ready,
    input  logic [nkc_pkg::COORD_W-1:0] touch_x,
    input  logic [nkc_pkg::COORD_W-1:0] touch_y,
    input  logic                       upper_case,
    output logic                       key_valid,
    input  logic                       key_ready,
    output logic [nkc_pkg::CODE_W-1:0]  key_code,
    output logic [nkc_pkg::IDX_W-1:0]   key_index
);

    localparam int LANES = (NUM_KEYS < nkc_pkg::LAYOUT_SIZE) ? NUM_KEYS
                                                             : nkc_pkg::LAYOUT_SIZE;
    localparam int LEVELS     = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int LEAVES     = 1 << LEVELS;
    localparam int TREE_FIRST = 5;
    localparam int NST        = TREE_FIRST + LEVELS + 1;

    logic [NST-1:0] v_reg;
    logic           en [NST+1];
    logic           up_reg [NST-1];

    logic [nkc_pkg::COORD_W-1:0] dx_reg  [LANES];
    logic [nkc_pkg::COORD_W-1:0] dy_reg  [LANES];
    logic [nkc_pkg::SUM_W-1:0]   sum_reg [LANES];
    nkc_pkg::sqrt_state_t        sq0_reg [LANES];
    nkc_pkg::sqrt_state_t        sq1_reg [LANES];
    nkc_pkg::sqrt_state_t        sq2_reg [LANES];

    logic [nkc_pkg::DIST_W-1:0] node_d     [1:2*LEAVES-1];
    logic [nkc_pkg::IDX_W-1:0]  node_i     [1:2*LEAVES-1];
    logic [nkc_pkg::DIST_W-1:0] node_d_reg [1:LEAVES-1];
    logic [nkc_pkg::IDX_W-1:0]  node_i_reg [1:LEAVES-1];

    logic [nkc_pkg::CODE_W-1:0] key_code_reg;
    logic [nkc_pkg::IDX_W-1:0]  key_index_reg;

    // stage enables, a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NST] = key_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign touch_ready = en[0];
    assign key_valid   = v_reg[NST-1];
    assign key_code    = key_code_reg;
    assign key_index   = key_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= touch_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // case flag travels with the request
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            up_reg[0] <= upper_case;
        end
        for (int k = 1; k < NST - 1; k++)
        begin
            if (en[k])
            begin
                up_reg[k] <= up_reg[k-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : gen_lane
            always_ff @(posedge clk)
            begin
                if (en[0])
                begin
                    dx_reg[g] <= (touch_x >= nkc_pkg::CENTRE_X[g])
                                 ? touch_x - nkc_pkg::CENTRE_X[g]
                                 : nkc_pkg::CENTRE_X[g] - touch_x;
                    dy_reg[g] <= (touch_y >= nkc_pkg::CENTRE_Y[g])
                                 ? touch_y - nkc_pkg::CENTRE_Y[g]
                                 : nkc_pkg::CENTRE_Y[g] - touch_y;
                end
                if (en[1])
                begin
                    sum_reg[g] <= nkc_pkg::SUM_W'(dx_reg[g] * dx_reg[g])
                                + nkc_pkg::SUM_W'(dy_reg[g] * dy_reg[g]);
                end
                if (en[2])
                begin
                    sq0_reg[g] <= nkc_pkg::sqrt_steps(
                        '{rad: {1'b0, sum_reg[g]}, rem: '0, root: '0}, 4);
                end
                if (en[3])
                begin
                    sq1_reg[g] <= nkc_pkg::sqrt_steps(sq0_reg[g], 4);
                end
                if (en[4])
                begin
                    sq2_reg[g] <= nkc_pkg::sqrt_steps(sq1_reg[g], 3);
                end
            end
        end

        // leaves of the min tree, unused leaves padded above any distance
        for (g = LEAVES; g < 2 * LEAVES; g++)
        begin : gen_leaf
            if (g - LEAVES < LANES)
            begin : gen_used
                assign node_d[g] = {1'b0, sq2_reg[g-LEAVES].root};
            end
            else
            begin : gen_pad
                assign node_d[g] = nkc_pkg::DIST_PAD;
            end
            assign node_i[g] = nkc_pkg::IDX_W'(g - LEAVES);
        end

        // inner nodes, lower index wins a tie
        for (g = 1; g < LEAVES; g++)
        begin : gen_node
            localparam int STG = TREE_FIRST + LEVELS - $clog2(g + 1);
            always_ff @(posedge clk)
            begin
                if (en[STG])
                begin
                    if (node_d[2*g+1] < node_d[2*g])
                    begin
                        node_d_reg[g] <= node_d[2*g+1];
                        node_i_reg[g] <= node_i[2*g+1];
                    end
                    else
                    begin
                        node_d_reg[g] <= node_d[2*g];
                        node_i_reg[g] <= node_i[2*g];
                    end
                end
            end
            assign node_d[g] = node_d_reg[g];
            assign node_i[g] = node_i_reg[g];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            key_code_reg  <= nkc_pkg::key_code_of(node_i[1], up_reg[NST-2]);
            key_index_reg <= node_i[1];
        end
    end

    `NKC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !key_valid, "result valid during reset")
    `NKC_ASSERT(a_stall_full, !touch_ready |-> (key_valid && !key_ready), "stall without full output")
    `NKC_ASSERT(a_index_range, key_valid |-> (key_index < nkc_pkg::IDX_W'(LANES)), "key index out of range")
    `NKC_ASSERT(a_space_code, (key_valid && key_index == nkc_pkg::IDX_W'(nkc_pkg::LAYOUT_SIZE - 1)) |-> (key_code == nkc_pkg::KC_SP), "space key code wrong")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for nearest_key_classifier: touch requests in, key results out
// predicts each nearest key from its own layout copy and compares results in order
// depends on nkc_pkg and the nearest_key_classifier rtl
`timescale 1ns / 1ps

module tb;

    localparam int KEYS           = 33;
    localparam int NUM_KEYS       = 33;
    localparam int LATENCY        = 12;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 520;

    typedef struct {
        logic [nkc_pkg::CODE_W-1:0] code;
        logic [nkc_pkg::IDX_W-1:0]  index;
    } key_result_t;

    localparam logic [nkc_pkg::COORD_W-1:0] KEY_X [KEYS] = '{
        20, 63, 105, 150, 193, 236, 279, 324, 367, 410, 455,
        37, 80, 123, 167, 210, 252, 296, 339, 382, 440,
        19, 60, 103, 145, 188, 232, 274, 317, 358, 401, 450,
        252
    };

    localparam logic [nkc_pkg::COORD_W-1:0] KEY_Y [KEYS] = '{
        175, 175, 175, 175, 175, 175, 175, 175, 175, 175, 175,
        214, 214, 214, 214, 214, 214, 214, 214, 214, 214,
        253, 253, 253, 253, 253, 253, 253, 253, 253, 253, 253,
        294
    };

    localparam logic [nkc_pkg::CODE_W-1:0] UPPER_CODES [KEYS] = '{
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50,
        nkc_pkg::KC_BS,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
        nkc_pkg::KC_RET,
        nkc_pkg::KC_SH, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h21, 7'h3F,
        nkc_pkg::KC_SH,
        nkc_pkg::KC_SP
    };

    localparam logic [nkc_pkg::CODE_W-1:0] LOWER_CODES [KEYS] = '{
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
        nkc_pkg::KC_BS,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
        nkc_pkg::KC_RET,
        nkc_pkg::KC_SH, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E,
        nkc_pkg::KC_SH,
        nkc_pkg::KC_SP
    };

    localparam int IDX_BACKSPACE = 10;
    localparam int IDX_RETURN    = 20;
    localparam int IDX_SHIFT_L   = 21;
    localparam int IDX_SHIFT_R   = 31;
    localparam int IDX_SPACE     = 32;

    logic                         clk;
    logic                         rst_n       = 1'b0;
    logic                         touch_valid = 1'b0;
    logic                         touch_ready;
    logic [nkc_pkg::COORD_W-1:0]  touch_x     = '0;
    logic [nkc_pkg::COORD_W-1:0]  touch_y     = '0;
    logic                         upper_case  = 1'b0;
    logic                         key_valid;
    logic                         key_ready   = 1'b0;
    logic [nkc_pkg::CODE_W-1:0]   key_code;
    logic [nkc_pkg::IDX_W-1:0]    key_index;

    key_result_t expected_keys [$];
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          hold_asks    = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    int          idle_cycles  = 0;
    int          mismatches   = 0;
    int          touches_sent = 0;
    int          keys_checked = 0;

    nearest_key_classifier #(
        .NUM_KEYS(NUM_KEYS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .touch_valid(touch_valid),
        .touch_ready(touch_ready),
        .touch_x(touch_x),
        .touch_y(touch_y),
        .upper_case(upper_case),
        .key_valid(key_valid),
        .key_ready(key_ready),
        .key_code(key_code),
        .key_index(key_index)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned floor_sqrt(input int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = 11; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (t * t <= v)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic key_result_t nearest_key(input logic [nkc_pkg::COORD_W-1:0] x,
                                                input logic [nkc_pkg::COORD_W-1:0] y,
                                                input logic up);
        key_result_t res;
        int unsigned best;
        int unsigned dx;
        int unsigned dy;
        int unsigned d;
        int          searched;
        best      = 32'hFFFF;
        res.code  = nkc_pkg::KC_SP;
        res.index = '0;
        searched  = (NUM_KEYS < KEYS) ? NUM_KEYS : KEYS;
        for (int i = 0; i < searched; i++)
        begin
            dx = (x >= KEY_X[i]) ? 32'(x - KEY_X[i]) : 32'(KEY_X[i] - x);
            dy = (y >= KEY_Y[i]) ? 32'(y - KEY_Y[i]) : 32'(KEY_Y[i] - y);
            d  = floor_sqrt(dx * dx + dy * dy);
            if (d < best)
            begin
                best      = d;
                res.index = nkc_pkg::IDX_W'(i);
                res.code  = up ? UPPER_CODES[i] : LOWER_CODES[i];
            end
        end
        return res;
    endfunction

    // receiver: random stalls, plus a long hold when asked
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            key_ready <= 1'b0;
        end
        else
        begin
            key_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        key_result_t want;
        if (key_valid && key_ready && rst_n)
        begin
            keys_checked++;
            if (expected_keys.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected key result: code %h index %0d", key_code, key_index);
                end
            end
            else
            begin
                want = expected_keys.pop_front();
                if (key_code !== want.code || key_index !== want.index)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("key mismatch: expected code %h index %0d, got code %h index %0d",
                                 want.code, want.index, key_code, key_index);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (touch_valid && touch_ready) || (key_valid && key_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic send_touch(input logic [nkc_pkg::COORD_W-1:0] x,
                              input logic [nkc_pkg::COORD_W-1:0] y,
                              input logic up);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            touch_valid <= 1'b0;
            @(negedge clk);
        end
        touch_valid <= 1'b1;
        touch_x     <= x;
        touch_y     <= y;
        upper_case  <= up;
        do
        begin
            @(posedge clk);
        end
        while (!touch_ready);
        expected_keys.push_back(nearest_key(x, y, up));
        touches_sent++;
        @(negedge clk);
    endtask

    task automatic test_extremes();
        send_touch(10'd0, 10'd0, 1'b0);
        send_touch(10'd0, 10'd0, 1'b1);
        send_touch(10'd1023, 10'd1023, 1'b0);
        send_touch(10'd1023, 10'd1023, 1'b1);
        send_touch(10'd1023, 10'd0, 1'b1);
        send_touch(10'd0, 10'd1023, 1'b0);
        send_touch(10'h155, 10'h2AA, 1'b1);
        send_touch(10'h2AA, 10'h155, 1'b0);
    endtask

    // points at or close to equal truncated distance from neighbouring keys
    task automatic test_ties();
        send_touch(10'd84, 10'd175, 1'b0);
        send_touch(10'd84, 10'd176, 1'b1);
        send_touch(10'd145, 10'd214, 1'b0);
        send_touch(10'd124, 10'd253, 1'b1);
        send_touch(10'd41, 10'd175, 1'b0);
        send_touch(10'd42, 10'd175, 1'b1);
    endtask

    task automatic test_special_keys();
        int specials [5];
        specials = '{IDX_BACKSPACE, IDX_RETURN, IDX_SHIFT_L, IDX_SHIFT_R, IDX_SPACE};
        foreach (specials[i])
        begin
            send_touch(KEY_X[specials[i]], KEY_Y[specials[i]], 1'b0);
            send_touch(KEY_X[specials[i]], KEY_Y[specials[i]], 1'b1);
        end
    endtask

    task automatic test_random(input int count);
        int                          pick;
        int                          k;
        logic [nkc_pkg::COORD_W-1:0] x;
        logic [nkc_pkg::COORD_W-1:0] y;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // anywhere over the keyboard area
                x = nkc_pkg::COORD_W'($urandom_range(0, 479));
                y = nkc_pkg::COORD_W'($urandom_range(150, 320));
            end
            else if (pick < 80)
            begin
                // close to a key centre
                k = $urandom_range(0, KEYS - 1);
                x = nkc_pkg::COORD_W'(KEY_X[k] + $urandom_range(0, 24) - 12);
                y = nkc_pkg::COORD_W'(KEY_Y[k] + $urandom_range(0, 24) - 12);
            end
            else
            begin
                x = nkc_pkg::COORD_W'($urandom_range(0, 1023));
                y = nkc_pkg::COORD_W'($urandom_range(0, 1023));
            end
            send_touch(x, y, 1'($urandom_range(0, 1)));
        end
    endtask

    // output held off while requests keep coming, so the pipeline fills
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asks++;
        test_random(64);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 24;
        rx_idle_pct = 53;
        test_extremes();
        test_ties();
        test_special_keys();
        test_random(RANDOM_ITEMS);

        tx_idle_pct = 53;
        rx_idle_pct = 24;
        test_random(RANDOM_ITEMS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(RANDOM_ITEMS);

        test_backpressure();

        touch_valid <= 1'b0;
        while (expected_keys.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);

        $display("%0d touch requests sent, %0d key results checked, %0d mismatches",
                 touches_sent, keys_checked, mismatches);
        $display("covered panel corners, ties, special keys, random points, stalls on both sides");
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
